>>> rtl/ppns_pkg.sv
// shared types, constants and helpers for the periodic pair neighbor search
package ppns_pkg;

    localparam int NUM_AXES      = 3;
    localparam int POS_W         = 24;
    localparam int BOX_W         = 23;
    localparam int MOL_W         = 16;
    localparam int GIDX_W        = 16;
    localparam int CUT_W         = 23;
    localparam int AD_W          = 24;
    localparam int SQ_W          = 2 * AD_W;
    localparam int SUM_W         = SQ_W + 2;
    localparam int CSQ_W         = 2 * CUT_W;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int MAX_SITES_DEF = 32;

    localparam logic [CUT_W-1:0] CUTOFF_RESET = 23'd327680;
    localparam logic             REG_CUTOFF   = 1'b0;
    localparam logic             MODE_HEADER  = 1'b0;
    localparam logic             MODE_SITE    = 1'b1;

    typedef logic [NUM_AXES-1:0][AD_W-1:0]  axis_vec_t;
    typedef logic [NUM_AXES-1:0][BOX_W-1:0] box_vec_t;

    typedef struct packed {
        logic [MOL_W-1:0]                 mol;
        logic [NUM_AXES-1:0][POS_W-1:0]   pos;
    } site_t;

    // control that travels with each pair through the chain
    typedef struct packed {
        logic valid;
        logic last;
        logic cand;
    } tok_ctl_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ISSUE  = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_EDGE_A = 6'b010000,
        ST_EDGE_B = 6'b100000
    } state_t;

    // global index with saturation at the top of the index range
    function automatic logic [GIDX_W-1:0] global_of(input logic [GIDX_W-1:0] base,
                                                    input logic [GIDX_W-1:0] loc);
        logic [GIDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, loc};
        global_of = sum[GIDX_W] ? {GIDX_W{1'b1}} : sum[GIDX_W-1:0];
    endfunction

endpackage

>>> rtl/ppns_cell.sv
// one restoring remainder step for all three axes, registered
module ppns_cell #(
    parameter int IDX_W   = $clog2(ppns_pkg::MAX_SITES_DEF),
    parameter int BIT_POS = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppns_pkg::box_vec_t   box,
    input  ppns_pkg::tok_ctl_t   in_ctl,
    input  logic [IDX_W-1:0]     in_idx,
    input  ppns_pkg::axis_vec_t  in_ad,
    input  ppns_pkg::axis_vec_t  in_rem,
    output ppns_pkg::tok_ctl_t   out_ctl,
    output logic [IDX_W-1:0]     out_idx,
    output ppns_pkg::axis_vec_t  out_ad,
    output ppns_pkg::axis_vec_t  out_rem
);

    ppns_pkg::tok_ctl_t  ctl_reg;
    logic [IDX_W-1:0]    idx_reg;
    ppns_pkg::axis_vec_t ad_reg;
    ppns_pkg::axis_vec_t rem_reg;
    ppns_pkg::axis_vec_t rem_next;

    always_comb
    begin
        logic [ppns_pkg::AD_W:0] trial;
        logic [ppns_pkg::AD_W:0] divisor;
        for (int a = 0; a < ppns_pkg::NUM_AXES; a++)
        begin
            trial   = {in_rem[a], in_ad[a][BIT_POS]};
            divisor = {{(ppns_pkg::AD_W + 1 - ppns_pkg::BOX_W){1'b0}}, box[a]};
            if (trial >= divisor)
            begin
                rem_next[a] = ppns_pkg::AD_W'(trial - divisor);
            end
            else
            begin
                rem_next[a] = ppns_pkg::AD_W'(trial);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= in_idx;
        ad_reg  <= in_ad;
        rem_reg <= rem_next;
    end

    assign out_ctl = ctl_reg;
    assign out_idx = idx_reg;
    assign out_ad  = ad_reg;
    assign out_rem = rem_reg;

endmodule

>>> rtl/periodic_pair_neighbor_search.sv
// top level of the periodic pair neighbor search
// A header transaction (mode 0) loads the box lengths and opens a frame; it gives no edges.
// A site transaction (mode 1) is stored and then compared with every earlier stored site of
// the frame, one pair entering the cell chain per cycle. Each pair runs through a chain of
// 24 remainder cells (one bit of |d| mod box per cell, all three axes side by side), then a
// min-image pick, a squaring stage and a sum stage. Hits are kept in a small list and then
// sent out as edges in both directions (partner to site, then site to partner), with last
// set on the final edge. A site with no earlier partner, or beyond MAX_SITES in the frame,
// starts no comparisons. No clearing pass is needed after reset.
module periodic_pair_neighbor_search #(
    parameter int MAX_SITES = ppns_pkg::MAX_SITES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppns_pkg::APB_AW-1:0]        paddr,
    input  logic [ppns_pkg::APB_DW-1:0]        pwdata,
    output logic [ppns_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic                               new_batch,
    input  logic [ppns_pkg::BOX_W-1:0]         box_x,
    input  logic [ppns_pkg::BOX_W-1:0]         box_y,
    input  logic [ppns_pkg::BOX_W-1:0]         box_z,
    input  logic [ppns_pkg::MOL_W-1:0]         mol_id,
    input  logic signed [ppns_pkg::POS_W-1:0]  pos_x,
    input  logic signed [ppns_pkg::POS_W-1:0]  pos_y,
    input  logic signed [ppns_pkg::POS_W-1:0]  pos_z,
    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ppns_pkg::GIDX_W-1:0]        source_index,
    output logic [ppns_pkg::GIDX_W-1:0]        target_index,
    output logic                               last
);

    localparam int IDX_W = $clog2(MAX_SITES);
    localparam int CNT_W = $clog2(MAX_SITES + 1);
    localparam int AD_W  = ppns_pkg::AD_W;

    // configuration
    logic [ppns_pkg::CUT_W-1:0] cutoff_reg;
    logic [ppns_pkg::CSQ_W-1:0] csq_reg;
    logic                       cfg_write;

    // frame state
    ppns_pkg::state_t           state_reg, state_next;
    ppns_pkg::box_vec_t         box_reg;
    logic [CNT_W-1:0]           frame_cnt_reg;
    logic [ppns_pkg::GIDX_W-1:0] base_reg;
    logic [ppns_pkg::GIDX_W-1:0] gcount_reg;
    logic [IDX_W-1:0]           n_reg;
    logic [ppns_pkg::GIDX_W-1:0] self_reg;
    ppns_pkg::site_t            new_site_reg;

    // issue and site store
    logic [IDX_W-1:0]           e_reg;
    ppns_pkg::site_t            site_mem [MAX_SITES];
    ppns_pkg::site_t            site_q_reg;
    ppns_pkg::tok_ctl_t         rd_ctl_reg;
    logic [IDX_W-1:0]           rd_idx_reg;

    // chain of remainder cells; entry 0 is the difference stage
    ppns_pkg::tok_ctl_t         ch_ctl [AD_W+1];
    logic [IDX_W-1:0]           ch_idx [AD_W+1];
    ppns_pkg::axis_vec_t        ch_ad  [AD_W+1];
    ppns_pkg::axis_vec_t        ch_rem [AD_W+1];
    ppns_pkg::tok_ctl_t         df_ctl_reg;
    logic [IDX_W-1:0]           df_idx_reg;
    ppns_pkg::axis_vec_t        df_ad_reg;

    // tail stages
    ppns_pkg::tok_ctl_t         r_ctl_reg, sq_ctl_reg, sm_ctl_reg;
    logic [IDX_W-1:0]           r_idx_reg, sq_idx_reg, sm_idx_reg;
    ppns_pkg::axis_vec_t        r_reg;
    logic [ppns_pkg::NUM_AXES-1:0][ppns_pkg::SQ_W-1:0] sq_reg;
    logic [ppns_pkg::SUM_W-1:0] sum_reg;
    logic                       hit;

    // hit list and edge output
    logic [IDX_W-1:0]           hl_mem [MAX_SITES];
    logic [IDX_W-1:0]           hl_q_reg;
    logic [IDX_W-1:0]           hit_cnt_reg;
    logic [IDX_W-1:0]           rd_ptr_reg;
    logic                       out_valid_reg;
    logic [ppns_pkg::GIDX_W-1:0] src_reg, tgt_reg;
    logic                       last_reg;
    logic                       slot_free;
    logic [ppns_pkg::GIDX_W-1:0] partner_g;
    logic                       in_acc;

    // apb side: one register, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ppns_pkg::REG_CUTOFF);
    assign prdata    = (paddr[2] == ppns_pkg::REG_CUTOFF)
                       ? ppns_pkg::APB_DW'(cutoff_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= ppns_pkg::CUTOFF_RESET;
        end
        else if (cfg_write)
        begin
            cutoff_reg <= pwdata[ppns_pkg::CUT_W-1:0];
        end
    end

    // squared cutoff, registered from the cutoff register
    always_ff @(posedge clk)
    begin
        csq_reg <= ppns_pkg::CSQ_W'(cutoff_reg) * ppns_pkg::CSQ_W'(cutoff_reg);
    end

    assign in_ready = (state_reg == ppns_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // control sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppns_pkg::ST_IDLE:
            begin
                if (in_acc && (mode == ppns_pkg::MODE_SITE)
                    && (frame_cnt_reg < CNT_W'(MAX_SITES)) && (frame_cnt_reg != '0))
                begin
                    state_next = ppns_pkg::ST_ISSUE;
                end
            end
            ppns_pkg::ST_ISSUE:
            begin
                if (e_reg == n_reg - 1'b1)
                begin
                    state_next = ppns_pkg::ST_DRAIN;
                end
            end
            ppns_pkg::ST_DRAIN:
            begin
                if (sm_ctl_reg.valid && sm_ctl_reg.last)
                begin
                    if (hit || (hit_cnt_reg != '0))
                    begin
                        state_next = ppns_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = ppns_pkg::ST_IDLE;
                    end
                end
            end
            ppns_pkg::ST_FETCH:
            begin
                state_next = ppns_pkg::ST_EDGE_A;
            end
            ppns_pkg::ST_EDGE_A:
            begin
                if (slot_free)
                begin
                    state_next = ppns_pkg::ST_EDGE_B;
                end
            end
            ppns_pkg::ST_EDGE_B:
            begin
                if (slot_free)
                begin
                    state_next = (rd_ptr_reg == hit_cnt_reg - 1'b1)
                                 ? ppns_pkg::ST_IDLE : ppns_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = ppns_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppns_pkg::ST_IDLE;
            box_reg       <= {ppns_pkg::NUM_AXES{ppns_pkg::BOX_W'(1)}};
            frame_cnt_reg <= '0;
            base_reg      <= '0;
            gcount_reg    <= '0;
            e_reg         <= '0;
            rd_ctl_reg    <= '0;
            hit_cnt_reg   <= '0;
            rd_ptr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // header: new frame, optional batch restart
            if (in_acc && (mode == ppns_pkg::MODE_HEADER))
            begin
                box_reg       <= {box_z, box_y, box_x};
                frame_cnt_reg <= '0;
                if (new_batch)
                begin
                    gcount_reg <= '0;
                    base_reg   <= '0;
                end
                else
                begin
                    base_reg <= gcount_reg;
                end
            end
            // site: count it globally, store it if the frame has room
            if (in_acc && (mode == ppns_pkg::MODE_SITE))
            begin
                if (gcount_reg != {ppns_pkg::GIDX_W{1'b1}})
                begin
                    gcount_reg <= gcount_reg + 1'b1;
                end
                if (frame_cnt_reg < CNT_W'(MAX_SITES))
                begin
                    frame_cnt_reg <= frame_cnt_reg + 1'b1;
                end
                e_reg       <= '0;
                hit_cnt_reg <= '0;
            end
            // one pair leaves the store per cycle while issuing
            rd_ctl_reg.valid <= (state_reg == ppns_pkg::ST_ISSUE);
            rd_ctl_reg.last  <= (state_reg == ppns_pkg::ST_ISSUE) && (e_reg == n_reg - 1'b1);
            rd_ctl_reg.cand  <= 1'b0;
            if (state_reg == ppns_pkg::ST_ISSUE)
            begin
                e_reg <= e_reg + 1'b1;
            end
            if (hit)
            begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (state_reg == ppns_pkg::ST_DRAIN)
            begin
                rd_ptr_reg <= '0;
            end
            else if ((state_reg == ppns_pkg::ST_EDGE_B) && slot_free)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // per-site payload captured at the transaction
    always_ff @(posedge clk)
    begin
        if (in_acc && (mode == ppns_pkg::MODE_SITE))
        begin
            n_reg        <= frame_cnt_reg[IDX_W-1:0];
            self_reg     <= ppns_pkg::global_of(base_reg, ppns_pkg::GIDX_W'(frame_cnt_reg));
            new_site_reg <= '{mol: mol_id, pos: {pos_z, pos_y, pos_x}};
        end
    end

    // site store: written at the transaction, read one pair a cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && (mode == ppns_pkg::MODE_SITE) && (frame_cnt_reg < CNT_W'(MAX_SITES)))
        begin
            site_mem[frame_cnt_reg[IDX_W-1:0]] <= '{mol: mol_id,
                                                    pos: {pos_z, pos_y, pos_x}};
        end
        site_q_reg <= site_mem[e_reg];
        rd_idx_reg <= e_reg;
    end

    // difference stage: |earlier - newer| per axis, molecule filter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            df_ctl_reg <= '0;
        end
        else
        begin
            df_ctl_reg.valid <= rd_ctl_reg.valid;
            df_ctl_reg.last  <= rd_ctl_reg.last;
            df_ctl_reg.cand  <= (site_q_reg.mol != new_site_reg.mol);
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [AD_W:0] d;
        for (int a = 0; a < ppns_pkg::NUM_AXES; a++)
        begin
            d = (AD_W+1)'(signed'(site_q_reg.pos[a])) - (AD_W+1)'(signed'(new_site_reg.pos[a]));
            df_ad_reg[a] <= d[AD_W] ? AD_W'(-d) : AD_W'(d);
        end
        df_idx_reg <= rd_idx_reg;
    end

    assign ch_ctl[0] = df_ctl_reg;
    assign ch_idx[0] = df_idx_reg;
    assign ch_ad[0]  = df_ad_reg;
    assign ch_rem[0] = '0;

    for (genvar k = 0; k < AD_W; k++)
    begin : g_cell
        ppns_cell #(
            .IDX_W   (IDX_W),
            .BIT_POS (AD_W - 1 - k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .box     (box_reg),
            .in_ctl  (ch_ctl[k]),
            .in_idx  (ch_idx[k]),
            .in_ad   (ch_ad[k]),
            .in_rem  (ch_rem[k]),
            .out_ctl (ch_ctl[k+1]),
            .out_idx (ch_idx[k+1]),
            .out_ad  (ch_ad[k+1]),
            .out_rem (ch_rem[k+1])
        );
    end

    // tail: nearest image, square, sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_ctl_reg  <= '0;
            sq_ctl_reg <= '0;
            sm_ctl_reg <= '0;
        end
        else
        begin
            r_ctl_reg  <= ch_ctl[AD_W];
            sq_ctl_reg <= r_ctl_reg;
            sm_ctl_reg <= sq_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [AD_W-1:0] bx;
        logic [AD_W-1:0] alt;
        for (int a = 0; a < ppns_pkg::NUM_AXES; a++)
        begin
            bx  = AD_W'(box_reg[a]);
            alt = bx - ch_rem[AD_W][a];
            // zero box: no wrap along this axis
            if (box_reg[a] == '0)
            begin
                r_reg[a] <= ch_ad[AD_W][a];
            end
            else if (ch_rem[AD_W][a] < alt)
            begin
                r_reg[a] <= ch_rem[AD_W][a];
            end
            else
            begin
                r_reg[a] <= alt;
            end
            sq_reg[a] <= ppns_pkg::SQ_W'(r_reg[a]) * ppns_pkg::SQ_W'(r_reg[a]);
        end
        sum_reg    <= ppns_pkg::SUM_W'(sq_reg[0]) + ppns_pkg::SUM_W'(sq_reg[1])
                    + ppns_pkg::SUM_W'(sq_reg[2]);
        r_idx_reg  <= ch_idx[AD_W];
        sq_idx_reg <= r_idx_reg;
        sm_idx_reg <= sq_idx_reg;
    end

    assign hit = sm_ctl_reg.valid && sm_ctl_reg.cand
                 && (sum_reg <= ppns_pkg::SUM_W'(csq_reg));

    // hit list
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            hl_mem[hit_cnt_reg] <= sm_idx_reg;
        end
        hl_q_reg <= hl_mem[rd_ptr_reg];
    end

    // edge output register
    assign slot_free = !out_valid_reg || out_ready;
    assign partner_g = ppns_pkg::global_of(base_reg, ppns_pkg::GIDX_W'(hl_q_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free && ((state_reg == ppns_pkg::ST_EDGE_A)
                               || (state_reg == ppns_pkg::ST_EDGE_B)))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && (state_reg == ppns_pkg::ST_EDGE_A))
        begin
            src_reg  <= partner_g;
            tgt_reg  <= self_reg;
            last_reg <= 1'b0;
        end
        else if (slot_free && (state_reg == ppns_pkg::ST_EDGE_B))
        begin
            src_reg  <= self_reg;
            tgt_reg  <= partner_g;
            last_reg <= (rd_ptr_reg == hit_cnt_reg - 1'b1);
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_index = src_reg;
    assign target_index = tgt_reg;
    assign last         = last_reg;

endmodule

>>> rtl/ppns_checker.sv
// port-level checks for the periodic pair neighbor search
module ppns_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pready,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [ppns_pkg::GIDX_W-1:0]   source_index,
    input logic [ppns_pkg::GIDX_W-1:0]   target_index,
    input logic                          last
);

    // a stalled edge stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("edge dropped while stalled");

    // a stalled edge keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(source_index) && $stable(target_index)
                                    && $stable(last))
        else $error("edge payload changed while stalled");

    // no new transaction is taken while a non-final edge of a site is offered
    a_busy_edges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken in the middle of an edge burst");

    // the register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port stalled");

endmodule

bind periodic_pair_neighbor_search ppns_checker u_ppns_checker (.*);
